// File: rtl/olt_pkg.sv
package olt_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths of the channels and the capacity register
    localparam int OP_W     = 3;
    localparam int POS_W    = 6;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int FIDX_W   = 6;
    localparam int RDV_W    = 32;
    localparam int LEN_W    = 7;
    localparam int CAP_W    = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_FIND   = 3'd2,
        OP_UPDATE = 3'd3,
        OP_GET    = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_READ,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] item_value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIDX_W-1:0]   found_index;
        logic [RDV_W-1:0]    read_value;
        logic [LEN_W-1:0]    length;
        logic                is_empty;
        logic                is_full;
    } rsp_t;

endpackage

// File: rtl/olt_req_if.sv
interface olt_req_if;
    logic                           valid;
    logic                           ready;
    logic [olt_pkg::OP_W-1:0]       operation;
    logic [olt_pkg::POS_W-1:0]      position;
    logic [olt_pkg::VAL_W-1:0]      item_value;

    modport source (output valid, output operation, output position, output item_value,
                    input ready);
    modport sink   (input valid, input operation, input position, input item_value,
                    output ready);
endinterface

// File: rtl/olt_rsp_if.sv
interface olt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [olt_pkg::STATUS_W-1:0]   status;
    logic [olt_pkg::FIDX_W-1:0]     found_index;
    logic [olt_pkg::RDV_W-1:0]      read_value;
    logic [olt_pkg::LEN_W-1:0]      length;
    logic                           is_empty;
    logic                           is_full;

    modport source (output valid, output status, output found_index, output read_value,
                    output length, output is_empty, output is_full, input ready);
    modport sink   (input valid, input status, input found_index, input read_value,
                    input length, input is_empty, input is_full, output ready);
endinterface

// File: rtl/ordered_list_table_unit.sv
// Ordered list table: a list of up to DEPTH words held in one RAM, with the
// live length limited by a capacity register.
//
// Channels: req carries one operation word (operation, position,
// item_value); rsp returns one result word (status, found_index,
// read_value, length, is_empty, is_full) per request, in request order.
// Both use valid/ready; a word moves on a clock edge with both high.
// cfg_we/cfg_wdata write the capacity register; write it only while idle.
// Capacity 0 acts as 1, values above DEPTH act as DEPTH.
//
// Timing: one request at a time; req.ready is high only while the
// sequencer is idle. Insert, delete and find walk the RAM one word per
// cycle. Update, clear and error answers go from the execute state
// straight to the done state; get passes through a read state first;
// req.ready returns in the cycle rsp.valid rises.
//
// Reset (rst_n low, asynchronous) empties the list and sets capacity to
// DEPTH. RAM contents are not cleared; only live entries are ever used.
// A result waits in the rsp register while the receiver stalls; the next
// request is still accepted and runs, then holds until the register frees.
module ordered_list_table_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    olt_req_if.sink                       req,
    olt_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [olt_pkg::CAP_W-1:0]     cfg_wdata
);

    localparam int CW = olt_pkg::CNT_W;

    logic [olt_pkg::CAP_W-1:0] cap_reg;
    logic [CW-1:0]             cap_eff;

    olt_pkg::req_t             req_word;
    olt_pkg::rsp_t             seq_rsp;
    logic                      seq_idle;
    logic                      seq_done;
    logic                      req_fire;
    logic                      rsp_free;

    logic                      rsp_valid_reg, rsp_valid_next;
    olt_pkg::rsp_t             rsp_data_reg, rsp_data_next;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= olt_pkg::CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // Clamp capacity into 1 .. DEPTH
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (CW'(cap_reg) > CW'(olt_pkg::DEPTH))
        begin
            cap_eff = CW'(olt_pkg::DEPTH);
        end
        else
        begin
            cap_eff = CW'(cap_reg);
        end
    end

    // Accept a request only while the sequencer is idle
    assign req.ready = seq_idle;
    assign req_fire  = req.valid && seq_idle;

    assign req_word.operation  = req.operation;
    assign req_word.position   = req.position;
    assign req_word.item_value = req.item_value;

    olt_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (req_fire),
        .req      (req_word),
        .cap      (cap_eff),
        .rsp_free (rsp_free),
        .idle     (seq_idle),
        .done     (seq_done),
        .rsp      (seq_rsp)
    );

    // Output register: free when empty or being drained this cycle
    assign rsp_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (rsp_free)
        begin
            rsp_valid_next = seq_done;
            if (seq_done)
            begin
                rsp_data_next = seq_rsp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_data_reg.status;
    assign rsp.found_index = rsp_data_reg.found_index;
    assign rsp.read_value  = rsp_data_reg.read_value;
    assign rsp.length      = rsp_data_reg.length;
    assign rsp.is_empty    = rsp_data_reg.is_empty;
    assign rsp.is_full     = rsp_data_reg.is_full;

endmodule

// File: rtl/olt_mem.sv
module olt_mem (
    input  logic                              clk,
    input  logic                              we,
    input  logic [olt_pkg::IDX_W-1:0]         waddr,
    input  logic [olt_pkg::DATA_WIDTH-1:0]    wdata,
    input  logic [olt_pkg::IDX_W-1:0]         raddr,
    output logic [olt_pkg::DATA_WIDTH-1:0]    rdata
);

    logic [olt_pkg::DATA_WIDTH-1:0] mem [olt_pkg::DEPTH];
    logic [olt_pkg::DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/olt_seq.sv
module olt_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  olt_pkg::req_t                 req,
    input  logic [olt_pkg::CNT_W-1:0]     cap,
    input  logic                          rsp_free,
    output logic                          idle,
    output logic                          done,
    output olt_pkg::rsp_t                 rsp
);

    localparam int IW = olt_pkg::IDX_W;
    localparam int CW = olt_pkg::CNT_W;
    localparam int DW = olt_pkg::DATA_WIDTH;

    olt_pkg::seq_state_t state_reg, state_next;
    olt_pkg::op_t        op_reg, op_next;
    logic [IW-1:0]       pos_reg, pos_next;
    logic [DW-1:0]       val_reg, val_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [IW-1:0]       ptr_reg, ptr_next;
    logic [IW-1:0]       wa_reg, wa_next;
    logic [CW-1:0]       left_reg, left_next;
    logic                pend_reg, pend_next;
    olt_pkg::status_t    status_reg, status_next;
    logic [IW-1:0]       found_reg, found_next;
    logic [DW-1:0]       rd_reg, rd_next;

    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    logic [DW-1:0]       mem_wdata;
    logic [IW-1:0]       mem_raddr;
    logic [DW-1:0]       mem_rdata;

    logic [CW-1:0]       pos_ext;

    olt_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign pos_ext = CW'(pos_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= olt_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        ptr_reg    <= ptr_next;
        wa_reg     <= wa_next;
        left_reg   <= left_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        rd_reg     <= rd_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        wa_next     = wa_reg;
        left_next   = left_reg;
        pend_next   = pend_reg;
        status_next = status_reg;
        found_next  = found_reg;
        rd_next     = rd_reg;
        mem_we      = 1'b0;
        mem_waddr   = wa_reg;
        mem_wdata   = mem_rdata;
        mem_raddr   = ptr_reg;
        idle        = 1'b0;
        done        = 1'b0;

        unique case (state_reg)
            olt_pkg::S_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    op_next     = olt_pkg::op_t'(req.operation);
                    pos_next    = IW'(req.position);
                    val_next    = DW'(req.item_value);
                    status_next = olt_pkg::ST_OK;
                    found_next  = '0;
                    rd_next     = '0;
                    pend_next   = 1'b0;
                    state_next  = olt_pkg::S_EXEC;
                end
            end

            olt_pkg::S_EXEC:
            begin
                state_next = olt_pkg::S_DONE;
                unique case (op_reg)
                    olt_pkg::OP_INSERT:
                    begin
                        if (pos_ext > count_reg)
                        begin
                            status_next = olt_pkg::ST_BADPOS;
                        end
                        else if (count_reg >= cap)
                        begin
                            status_next = olt_pkg::ST_FULL;
                        end
                        else
                        begin
                            // move entries count-1 .. pos up by one, top first
                            left_next  = count_reg - pos_ext;
                            ptr_next   = IW'(count_reg - CW'(1));
                            state_next = olt_pkg::S_SCAN;
                        end
                    end
                    olt_pkg::OP_DELETE:
                    begin
                        if (pos_ext >= count_reg)
                        begin
                            status_next = olt_pkg::ST_BADPOS;
                        end
                        else
                        begin
                            // move entries pos+1 .. count-1 down by one
                            left_next  = count_reg - pos_ext - CW'(1);
                            ptr_next   = pos_reg + IW'(1);
                            state_next = olt_pkg::S_SCAN;
                        end
                    end
                    olt_pkg::OP_FIND:
                    begin
                        left_next  = count_reg;
                        ptr_next   = '0;
                        state_next = olt_pkg::S_SCAN;
                    end
                    olt_pkg::OP_UPDATE:
                    begin
                        if (pos_ext >= count_reg)
                        begin
                            status_next = olt_pkg::ST_BADPOS;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = pos_reg;
                            mem_wdata = val_reg;
                        end
                    end
                    olt_pkg::OP_GET:
                    begin
                        if (pos_ext >= count_reg)
                        begin
                            status_next = olt_pkg::ST_BADPOS;
                        end
                        else
                        begin
                            mem_raddr  = pos_reg;
                            state_next = olt_pkg::S_READ;
                        end
                    end
                    olt_pkg::OP_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        state_next = olt_pkg::S_DONE;
                    end
                endcase
            end

            olt_pkg::S_SCAN:
            begin
                // retire the word read last cycle, then issue the next read
                if (pend_reg && op_reg == olt_pkg::OP_FIND && mem_rdata == val_reg)
                begin
                    status_next = olt_pkg::ST_OK;
                    found_next  = wa_reg;
                    pend_next   = 1'b0;
                    state_next  = olt_pkg::S_DONE;
                end
                else
                begin
                    if (pend_reg && op_reg != olt_pkg::OP_FIND)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = wa_reg;
                        mem_wdata = mem_rdata;
                    end

                    if (left_reg != '0)
                    begin
                        mem_raddr = ptr_reg;
                        pend_next = 1'b1;
                        left_next = left_reg - CW'(1);
                        if (op_reg == olt_pkg::OP_INSERT)
                        begin
                            wa_next  = ptr_reg + IW'(1);
                            ptr_next = ptr_reg - IW'(1);
                        end
                        else if (op_reg == olt_pkg::OP_DELETE)
                        begin
                            wa_next  = ptr_reg - IW'(1);
                            ptr_next = ptr_reg + IW'(1);
                        end
                        else
                        begin
                            wa_next  = ptr_reg;
                            ptr_next = ptr_reg + IW'(1);
                        end
                    end
                    else if (pend_reg)
                    begin
                        pend_next = 1'b0;
                    end
                    else
                    begin
                        state_next = olt_pkg::S_DONE;
                        if (op_reg == olt_pkg::OP_INSERT)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = pos_reg;
                            mem_wdata  = val_reg;
                            count_next = count_reg + CW'(1);
                        end
                        else if (op_reg == olt_pkg::OP_DELETE)
                        begin
                            count_next = count_reg - CW'(1);
                        end
                        else
                        begin
                            status_next = olt_pkg::ST_NOTFOUND;
                        end
                    end
                end
            end

            olt_pkg::S_READ:
            begin
                rd_next    = mem_rdata;
                state_next = olt_pkg::S_DONE;
            end

            olt_pkg::S_DONE:
            begin
                done = 1'b1;
                if (rsp_free)
                begin
                    state_next = olt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = olt_pkg::S_IDLE;
            end
        endcase
    end

    assign rsp.status      = status_reg;
    assign rsp.found_index = olt_pkg::FIDX_W'(found_reg);
    assign rsp.read_value  = olt_pkg::RDV_W'(rd_reg);
    assign rsp.length      = olt_pkg::LEN_W'(count_reg);
    assign rsp.is_empty    = (count_reg == '0);
    assign rsp.is_full     = (count_reg >= cap);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(olt_pkg::DEPTH))
        else $error("live count above depth");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == olt_pkg::S_SCAN |-> left_reg <= count_reg)
        else $error("scan length exceeds live count");

    a_write_live: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> CW'(mem_waddr) <= count_reg)
        else $error("write beyond end of list");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != olt_pkg::S_EXEC && state_reg != olt_pkg::S_SCAN
        |=> $stable(count_reg))
        else $error("count changed outside an operation");

endmodule
